// ----- hw/rtl/vector3_normalize_macros.svh -----
// Assertion macros for the vector3_normalize block.
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH
`ifndef SYNTHESIS
`define VN_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector3_normalize: same-cycle check failed");
`define VN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector3_normalize: next-cycle check failed");
`else
`define VN_ASSERT_IMPL(label, ante, cons)
`define VN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/vn_pkg.sv -----
// Shared types and constants for the vector3_normalize block.
package vn_pkg;
    localparam int COMP_W      = 32;
    localparam int SQ_W        = 64;
    localparam int LEN_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int NUM_W       = LEN_W + FRAC_W;
    localparam int Q_W         = FRAC_W + 1;
    localparam int UNIT_W      = Q_W + 1;
    localparam int LANES       = 3;
    localparam int SQRT_STAGES = LEN_W;
    localparam int SIDE_W      = LANES * (COMP_W + 1);

    typedef struct packed {
        logic adv;
        logic valid;
    } pipe_ctl_t;
endpackage

// ----- hw/rtl/vn_sqrt.sv -----
// Pipelined floor square root, one root bit per stage, with side payload.
module vn_sqrt
    import vn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_ctl_t         ctl,
    input  logic [SQ_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid,
    output logic [LEN_W-1:0]  root,
    output logic [SIDE_W-1:0] side_out
);
    logic [SQ_W-1:0]   rem_reg  [SQRT_STAGES];
    logic [SQ_W-1:0]   root_reg [SQRT_STAGES];
    logic [SIDE_W-1:0] side_reg [SQRT_STAGES];
    logic              v_reg    [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        localparam int BitPos = 2 * (SQRT_STAGES - 1 - s);
        logic [SQ_W-1:0]   rem_in;
        logic [SQ_W-1:0]   root_in;
        logic [SIDE_W-1:0] side_src;
        logic              v_src;
        logic [SQ_W-1:0]   trial;
        logic [SQ_W-1:0]   rem_next;
        logic [SQ_W-1:0]   root_next;

        if (s == 0) begin : g_first
            assign rem_in   = radicand;
            assign root_in  = '0;
            assign side_src = side_in;
            assign v_src    = ctl.valid;
        end
        else begin : g_rest
            assign rem_in   = rem_reg[s-1];
            assign root_in  = root_reg[s-1];
            assign side_src = side_reg[s-1];
            assign v_src    = v_reg[s-1];
        end

        assign trial = root_in + (SQ_W'(1) << BitPos);

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = (root_in >> 1) + (SQ_W'(1) << BitPos);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (ctl.adv)
                v_reg[s] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                side_reg[s] <= side_src;
            end
        end
    end

    assign valid    = v_reg[SQRT_STAGES-1];
    assign root     = root_reg[SQRT_STAGES-1][LEN_W-1:0];
    assign side_out = side_reg[SQRT_STAGES-1];
endmodule

// ----- hw/rtl/vn_div.sv -----
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module vn_div
    import vn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pipe_ctl_t                ctl,
    input  logic [NUM_W-1:0]         num [LANES],
    input  logic [LANES-1:0]         neg,
    input  logic [LEN_W-1:0]         den,
    input  logic                     zero,
    output logic                     valid,
    output logic [LEN_W-1:0]         den_out,
    output logic                     zero_out,
    output logic signed [UNIT_W-1:0] unit [LANES]
);
    logic [LEN_W-1:0]  den_reg  [Q_W];
    logic [LANES-1:0]  neg_reg  [Q_W];
    logic              zero_reg [Q_W];
    logic              v_reg    [Q_W];
    logic [NUM_W-1:0]  r_reg    [Q_W][LANES];
    logic [Q_W-1:0]    q_reg    [Q_W][LANES];

    logic              v_out_reg;
    logic [LEN_W-1:0]  den_out_reg;
    logic              zero_out_reg;
    logic [UNIT_W-1:0] unit_reg [LANES];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int BitPos = Q_W - 1 - s;
        logic [LEN_W-1:0] den_src;
        logic [LANES-1:0] neg_src;
        logic             zero_src;
        logic             v_src;
        logic [NUM_W-1:0] dsh;

        if (s == 0) begin : g_first
            assign den_src  = den;
            assign neg_src  = neg;
            assign zero_src = zero;
            assign v_src    = ctl.valid;
        end
        else begin : g_rest
            assign den_src  = den_reg[s-1];
            assign neg_src  = neg_reg[s-1];
            assign zero_src = zero_reg[s-1];
            assign v_src    = v_reg[s-1];
        end

        assign dsh = NUM_W'(den_src) << BitPos;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (ctl.adv)
                v_reg[s] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                den_reg[s]  <= den_src;
                neg_reg[s]  <= neg_src;
                zero_reg[s] <= zero_src;
            end
        end

        for (genvar k = 0; k < LANES; k++) begin : g_lane
            logic [NUM_W-1:0] r_in;
            logic [Q_W-1:0]   q_in;
            logic [NUM_W-1:0] r_next;
            logic [Q_W-1:0]   q_next;

            if (s == 0) begin : g_first
                assign r_in = num[k];
                assign q_in = '0;
            end
            else begin : g_rest
                assign r_in = r_reg[s-1][k];
                assign q_in = q_reg[s-1][k];
            end

            always_comb
            begin
                if (r_in >= dsh)
                begin
                    r_next = r_in - dsh;
                    q_next = q_in | (Q_W'(1) << BitPos);
                end
                else
                begin
                    r_next = r_in;
                    q_next = q_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctl.adv)
                begin
                    r_reg[s][k] <= r_next;
                    q_reg[s][k] <= q_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_out_reg <= 1'b0;
        else if (ctl.adv)
            v_out_reg <= v_reg[Q_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            den_out_reg  <= den_reg[Q_W-1];
            zero_out_reg <= zero_reg[Q_W-1];
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_sign
        logic [UNIT_W-1:0] qx;
        logic [UNIT_W-1:0] unit_next;

        assign qx = {1'b0, q_reg[Q_W-1][k]};

        always_comb
        begin
            if (zero_reg[Q_W-1])
                unit_next = '0;
            else if (neg_reg[Q_W-1][k])
                unit_next = ~qx + 1'b1;
            else
                unit_next = qx;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
                unit_reg[k] <= unit_next;
        end

        assign unit[k] = signed'(unit_reg[k]);
    end

    assign valid    = v_out_reg;
    assign den_out  = den_out_reg;
    assign zero_out = zero_out_reg;
endmodule

// ----- hw/rtl/vector3_normalize.sv -----
// Top level: length and unit vector of a signed Q16.16 3-vector.
// One vector is accepted every cycle while vec_stall is low; the pipeline has one stage
// for magnitudes, one for the three squares, two for the 64-bit sum, 32 for the square
// root (one root bit per stage), 17 for the three quotients (one bit per stage) and one
// for sign and zero handling. A stall on the result side freezes the whole pipeline;
// vec_stall follows it in the same cycle when the output holds a beat.
module vector3_normalize
    import vn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     vec_valid,
    output logic                     vec_stall,
    input  logic signed [COMP_W-1:0] comp_x,
    input  logic signed [COMP_W-1:0] comp_y,
    input  logic signed [COMP_W-1:0] comp_z,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [LEN_W-1:0]         length,
    output logic signed [UNIT_W-1:0] unit_x,
    output logic signed [UNIT_W-1:0] unit_y,
    output logic signed [UNIT_W-1:0] unit_z,
    output logic                     zero_vector
);
`include "vector3_normalize_macros.svh"

    logic              adv;
    logic [COMP_W-1:0] comp [LANES];

    logic              v1_reg;
    logic [COMP_W-1:0] mag1_reg [LANES];
    logic [LANES-1:0]  neg1_reg;

    logic              v2_reg;
    logic [SQ_W-1:0]   sq2_reg [LANES];
    logic [SIDE_W-1:0] side2_reg;

    logic              v3_reg;
    logic [SQ_W-1:0]   sxy3_reg;
    logic [SQ_W-1:0]   sz3_reg;
    logic [SIDE_W-1:0] side3_reg;

    logic              v4_reg;
    logic [SQ_W-1:0]   sum4_reg;
    logic [SIDE_W-1:0] side4_reg;

    logic              sq_valid;
    logic [LEN_W-1:0]  root;
    logic [SIDE_W-1:0] root_side;
    logic [NUM_W-1:0]  num [LANES];
    logic [LANES-1:0]  neg_root;
    logic signed [UNIT_W-1:0] unit [LANES];
    pipe_ctl_t         sq_ctl;
    pipe_ctl_t         div_ctl;

    assign adv       = !res_valid || !res_stall;
    assign vec_stall = !adv;

    assign comp[0] = comp_x;
    assign comp[1] = comp_y;
    assign comp[2] = comp_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= vec_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mag1_reg[k] <= comp[k][COMP_W-1] ? (~comp[k] + 1'b1) : comp[k];
                neg1_reg[k] <= comp[k][COMP_W-1];
                sq2_reg[k]  <= SQ_W'(mag1_reg[k]) * SQ_W'(mag1_reg[k]);
            end
        end

        assign num[k]      = {root_side[k*COMP_W +: COMP_W], FRAC_W'(0)};
        assign neg_root[k] = root_side[LANES*COMP_W + k];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side2_reg <= {neg1_reg, mag1_reg[2], mag1_reg[1], mag1_reg[0]};
            sxy3_reg  <= sq2_reg[0] + sq2_reg[1];
            sz3_reg   <= sq2_reg[2];
            side3_reg <= side2_reg;
            sum4_reg  <= sxy3_reg + sz3_reg;
            side4_reg <= side3_reg;
        end
    end

    assign sq_ctl  = '{adv: adv, valid: v4_reg};
    assign div_ctl = '{adv: adv, valid: sq_valid};

    vn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sq_ctl),
        .radicand (sum4_reg),
        .side_in  (side4_reg),
        .valid    (sq_valid),
        .root     (root),
        .side_out (root_side)
    );

    vn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .num      (num),
        .neg      (neg_root),
        .den      (root),
        .zero     (root == '0),
        .valid    (res_valid),
        .den_out  (length),
        .zero_out (zero_vector),
        .unit     (unit)
    );

    assign unit_x = unit[0];
    assign unit_y = unit[1];
    assign unit_z = unit[2];

    `VN_ASSERT_IMPL(a_zero_outputs, res_valid && zero_vector, length == '0 && unit_x == '0 && unit_y == '0 && unit_z == '0)
    `VN_ASSERT_IMPL(a_nonzero_len, res_valid && !zero_vector, length != '0)
    `VN_ASSERT_IMPL(a_stall_cause, vec_stall, res_valid && res_stall)
endmodule

// ----- dv/tb_vector3_normalize.sv -----
// Testbench for vector3_normalize: directed and random vectors checked against a length/unit predictor.
module tb_vector3_normalize;
    import vn_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic vec_valid = 1'b0;
    logic vec_stall;
    logic signed [COMP_W-1:0] comp_x = '0;
    logic signed [COMP_W-1:0] comp_y = '0;
    logic signed [COMP_W-1:0] comp_z = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic [LEN_W-1:0] length;
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic zero_vector;

    typedef struct {
        logic [LEN_W-1:0] len;
        logic [UNIT_W-1:0] ux;
        logic [UNIT_W-1:0] uy;
        logic [UNIT_W-1:0] uz;
        logic zero;
    } norm_t;

    norm_t norm_q[$];
    int errors = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int zero_seen = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY = 54;

    vector3_normalize dut (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] mag_of(logic [COMP_W-1:0] c);
        return c[COMP_W-1] ? 64'h1_0000_0000 - {32'd0, c} : {32'd0, c};
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] s);
        logic [63:0] r;
        logic [127:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = (r | (64'd1 << b)) * (r | (64'd1 << b));
            if (t <= {64'd0, s})
                r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [UNIT_W-1:0] unit_of(logic [COMP_W-1:0] c, logic [63:0] len);
        logic [63:0] q;
        q = (mag_of(c) << 16) / len;
        if (c[COMP_W-1])
            q = -q;
        return q[UNIT_W-1:0];
    endfunction

    function automatic norm_t normalize(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                                        logic [COMP_W-1:0] z);
        norm_t n;
        logic [63:0] sum;
        logic [63:0] len;
        sum = mag_of(x) * mag_of(x) + mag_of(y) * mag_of(y) + mag_of(z) * mag_of(z);
        len = isqrt64(sum);
        n.len = len[LEN_W-1:0];
        n.zero = (len == 0);
        n.ux = n.zero ? '0 : unit_of(x, len);
        n.uy = n.zero ? '0 : unit_of(y, len);
        n.uz = n.zero ? '0 : unit_of(z, len);
        return n;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH beat %0d %s: got %h expected %h", beats_checked, what, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("vector3_normalize verification failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        norm_t e;
        if (rst_n && res_valid && !res_stall) begin
            if (norm_q.size() == 0) begin
                report("unexpected beat", length, 0);
            end
            else begin
                e = norm_q.pop_front();
                if (length !== e.len) report("length", length, e.len);
                if (unit_x !== e.ux) report("unit_x", unit_x, e.ux);
                if (unit_y !== e.uy) report("unit_y", unit_y, e.uy);
                if (unit_z !== e.uz) report("unit_z", unit_z, e.uz);
                if (zero_vector !== e.zero) report("zero_vector", zero_vector, e.zero);
                if (e.zero) zero_seen++;
            end
            beats_checked++;
        end
    end

    always @(negedge clk)
        res_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic send_vec(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                            logic [COMP_W-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            vec_valid <= 1'b0;
            @(negedge clk);
        end
        vec_valid <= 1'b1;
        comp_x <= x;
        comp_y <= y;
        comp_z <= z;
        @(posedge clk);
        while (vec_stall)
            @(posedge clk);
        norm_q.push_back(normalize(x, y, z));
        beats_sent++;
        @(negedge clk);
    endtask

    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(255) - 128;
            2: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(1) == 1}};
            3: return 32'h8000_0000 ^ $urandom_range(3);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    task automatic test_directed();
        send_vec(0, 0, 0);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vec(32'h8000_0000, 0, 0);
        send_vec(0, 32'h7FFF_FFFF, 0);
        send_vec(0, 0, 32'hFFFF_FFFF);
        send_vec(1, 0, 0);
        send_vec(0, 32'hFFFF_FFFF, 1);
        send_vec(32'h0001_0000, 0, 0);
        send_vec(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
        send_vec(32'h0003_0000, 32'h0004_0000, 0);
        send_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    endtask

    task automatic test_random(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            send_vec(rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic drain();
        while (norm_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(275, 0, 0);
        test_random(275, 60, 0);
        test_random(275, 0, 60);
        test_random(275, 35, 35);
        vec_valid <= 1'b0;
        recv_stall_pct = 0;
        drain();
        $display("sent %0d vectors, checked %0d results (%0d zero vectors)",
                 beats_sent, beats_checked, zero_seen);
        $display("idle phases: none, sender 60%%, receiver 60%%, both 35%%");
        if (errors == 0 && beats_checked == beats_sent)
            $display("vector3_normalize verification clean");
        else
            $display("vector3_normalize verification failed");
        $finish;
    end
endmodule
